### rtl/asrtab_pkg.sv
// ============================================================================
// Aging sensor reading table: shared package
// Sequencer states, action and status codes, timing constants and the ASCII
// hex character function.
// ============================================================================
package asrtab_pkg;

  localparam int STAMP_W   = 32;
  localparam int READING_W = 40;
  localparam int LIMIT_W   = 29;

  localparam logic [12:0] TICKS_PER_MINUTE = 13'd6000;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'd57;
  localparam logic [7:0] ASCII_GAP  = 8'd7;

  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_SWEEP = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_ZERO  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_SWEEP,
    ST_CLEAR
  } state_t;

  // Uppercase ASCII character for one nibble.
  function automatic logic [7:0] ascii_nibble(input logic [3:0] v);
    logic [7:0] c;
    c = ASCII_ZERO + {4'd0, v};
    if (c > ASCII_NINE) begin
      c = c + ASCII_GAP;
    end
    return c;
  endfunction

endpackage

### rtl/asrtab_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ============================================================================
module asrtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/asrtab_age_cmp.sv
// ============================================================================
// Aging sensor reading table: age compare unit
// Wrapping age subtraction and limit compare, shared by every sweep step.
// ============================================================================
module asrtab_age_cmp (
  input  logic [asrtab_pkg::STAMP_W-1:0] now_ticks,
  input  logic [asrtab_pkg::STAMP_W-1:0] stamp,
  input  logic [asrtab_pkg::LIMIT_W-1:0] limit,
  output logic                           expire
);

  import asrtab_pkg::*;

  logic [STAMP_W-1:0] age;

  // The subtraction wraps modulo 2^32, so a stamp ahead of now reads as old.
  assign age    = now_ticks - stamp;
  assign expire = (stamp != '0) && (age >= STAMP_W'(limit));

endmodule

### rtl/aging_sensor_reading_table_top.sv
// ============================================================================
// Aging sensor reading table: top level
// Per-device reading table with arrival stamps, timeout sweep and hex read.
// ============================================================================
// An item is taken at a rising edge with start high and busy low, and each
// item gives exactly one result, shown for one cycle with done high; the
// receiver cannot hold it off, so it must take it then. A store, or any item
// whose index is zero or beyond the table, passes through the decode state
// before its done cycle, and a read also passes through a read-wait state
// for the registered read of the table memory. A sweep visits one entry per
// cycle through the single age compare unit; clear-all writes one entry per
// cycle. After reset the block runs a clearing pass with busy high and no
// result. The timeout register may be written at any time, but it is
// sampled when an item is accepted.
// ============================================================================
module aging_sensor_reading_table_top #(
  parameter int ENTRIES         = 256,
  parameter int BYTES_PER_ENTRY = 5
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  device_index,
  input  logic [39:0] reading,
  input  logic [31:0] now_ticks,
  // Result channel
  output logic        done,
  output logic [1:0]  status,
  output logic [39:0] reading_out,
  output logic [39:0] hex_high,
  output logic [39:0] hex_low,
  output logic        entry_live,
  output logic [8:0]  cleared_count,
  output logic        stale_seen,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  import asrtab_pkg::*;

  // Table geometry. Only the first KEEP bytes of a reading are stored, so
  // the memory word is those bytes followed by the arrival stamp.
  localparam int AW   = $clog2(ENTRIES);
  localparam int KEEP = (BYTES_PER_ENTRY > 5) ? 5 : ((BYTES_PER_ENTRY < 1) ? 1 : BYTES_PER_ENTRY);
  localparam int RB   = 8 * KEEP;
  localparam int RW   = RB + STAMP_W;

  localparam logic [15:0]   ENTRIES16  = 16'(ENTRIES);
  localparam logic [AW:0]   IDX_END    = (AW + 1)'(ENTRIES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(ENTRIES - 1);

  // Sequencer and working registers.
  state_t              state, state_next;
  logic [AW:0]         idx, idx_next;
  logic                pend, pend_next;
  logic [AW-1:0]       pend_addr;
  logic [8:0]          cnt, cnt_next;
  logic                stale, stale_next;
  logic                clear_item, clear_item_next;
  logic [15:0]         timeout_minutes;
  logic [LIMIT_W-1:0]  limit;

  // Item fields held for the length of the item.
  action_t             act;
  logic [7:0]          dev;
  logic [READING_W-1:0] rdg;
  logic [STAMP_W-1:0]  now_q;

  // Table memory ports.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [RW-1:0]       ram_rdata;

  // Result being finished in this cycle.
  logic                done_next;
  logic                fin;
  logic [1:0]          f_status;
  logic [39:0]         f_reading;
  logic [39:0]         f_hex_high;
  logic [39:0]         f_hex_low;
  logic                f_live;

  // Decode helpers.
  logic [15:0]         slot16;
  logic [AW-1:0]       slot;
  logic                idx_zero;
  logic                idx_range;
  logic [79:0]         rd_wide;
  logic [39:0]         rd_full;
  logic                expire;

  logic                accept;

  // Result registers.
  logic [1:0]          res_status;
  logic [39:0]         res_reading;
  logic [39:0]         res_hex_high;
  logic [39:0]         res_hex_low;
  logic                res_live;
  logic [8:0]          res_cleared;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);

  // Device numbers are 1-based; the slot is the number less one.
  assign slot16    = {8'd0, dev} - 16'd1;
  assign slot      = slot16[AW-1:0];
  assign idx_zero  = (dev == 8'd0);
  assign idx_range = ({8'd0, dev} > ENTRIES16);

  // Stored bytes sit at the top of the reading, lower bytes read as zero.
  assign rd_wide   = {ram_rdata[RW-1:STAMP_W], {(80 - RB){1'b0}}};
  assign rd_full   = rd_wide[79:40];

  asrtab_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  asrtab_age_cmp u_age (
    .now_ticks (now_q),
    .stamp     (ram_rdata[STAMP_W-1:0]),
    .limit     (limit),
    .expire    (expire)
  );

  // State register and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      idx             <= '0;
      pend            <= 1'b0;
      cnt             <= '0;
      stale           <= 1'b0;
      clear_item      <= 1'b0;
      done            <= 1'b0;
      timeout_minutes <= 16'd1;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      pend       <= pend_next;
      cnt        <= cnt_next;
      stale      <= stale_next;
      clear_item <= clear_item_next;
      done       <= done_next;
      if (cfg_wr_en) begin
        timeout_minutes <= cfg_wr_data;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    pend_addr <= ram_raddr;
    if (accept) begin
      act   <= action_t'(action);
      dev   <= device_index;
      rdg   <= reading;
      now_q <= now_ticks;
      limit <= LIMIT_W'(timeout_minutes) * LIMIT_W'(TICKS_PER_MINUTE);
    end
    if (fin) begin
      res_status   <= f_status;
      res_reading  <= f_reading;
      res_hex_high <= f_hex_high;
      res_hex_low  <= f_hex_low;
      res_live     <= f_live;
      res_cleared  <= cnt_next;
    end
  end

  // Sequencer: next state, memory control and the result being finished.
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    pend_next       = 1'b0;
    cnt_next        = cnt;
    stale_next      = stale;
    clear_item_next = clear_item;
    done_next       = 1'b0;
    fin             = 1'b0;
    f_status        = STAT_DONE;
    f_reading       = '0;
    f_hex_high      = '0;
    f_hex_low       = '0;
    f_live          = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = idx[AW-1:0];
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = idx[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DECODE;
        end
      end

      ST_DECODE: begin
        cnt_next = '0;
        idx_next = '0;
        unique case (act)
          ACT_STORE, ACT_READ: begin
            if (idx_zero || idx_range) begin
              f_status   = idx_zero ? STAT_ZERO : STAT_RANGE;
              fin        = 1'b1;
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end else if (act == ACT_STORE) begin
              ram_we     = 1'b1;
              ram_waddr  = slot;
              ram_wdata  = {rdg[READING_W-1 -: RB], now_q};
              f_live     = (now_q != '0);
              fin        = 1'b1;
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = slot;
              state_next = ST_READ_WAIT;
            end
          end
          ACT_SWEEP: begin
            state_next = ST_SWEEP;
          end
          ACT_CLEAR: begin
            clear_item_next = 1'b1;
            state_next      = ST_CLEAR;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_READ_WAIT: begin
        f_reading = rd_full;
        for (int k = 0; k < 5; k++) begin
          f_hex_high[39 - 8 * k -: 8] = ascii_nibble(rd_full[39 - 4 * k -: 4]);
          f_hex_low[39 - 8 * k -: 8]  = ascii_nibble(rd_full[19 - 4 * k -: 4]);
        end
        f_live     = (ram_rdata[STAMP_W-1:0] != '0);
        fin        = 1'b1;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      ST_SWEEP: begin
        // Read entry idx while the entry read last cycle is judged.
        if (idx != IDX_END) begin
          ram_re    = 1'b1;
          pend_next = 1'b1;
          idx_next  = idx + 1'b1;
        end
        if (pend && expire) begin
          ram_we     = 1'b1;
          ram_waddr  = pend_addr;
          ram_wdata  = '0;
          stale_next = 1'b1;
          if (cnt != 9'h1FF) begin
            cnt_next = cnt + 9'd1;
          end
        end
        if (idx == IDX_END) begin
          fin        = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        ram_wdata = '0;
        idx_next  = idx + 1'b1;
        if (idx[AW-1:0] == LAST_ENTRY) begin
          fin             = clear_item;
          done_next       = clear_item;
          clear_item_next = 1'b0;
          idx_next        = '0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign status        = res_status;
  assign reading_out   = res_reading;
  assign hex_high      = res_hex_high;
  assign hex_low       = res_hex_low;
  assign entry_live    = res_live;
  assign cleared_count = res_cleared;
  assign stale_seen    = stale;

`ifndef SYNTH
  // Every item passes through the decode state, so two
  // strobes never follow each other directly.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held high for two cycles");

  // An accepted item must make the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after accepting an item");

  // The table is never written while the block is idle.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("table written while idle");

  // A sweep cannot expire more entries than the table holds.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(cleared_count) <= ENTRIES))
    else $error("cleared count beyond table size");
`endif

endmodule

### verif/tb_aging_sensor_reading_table_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Aging sensor reading table: testbench
// Drives store, sweep, read and clear-all items through the command port and
// checks every result against a typed-in value or a cycle-free model of the
// table kept here. A short table of directed items comes first, then random
// traffic in phases under different timeout settings.
// ============================================================================
module tb_aging_sensor_reading_table_top;
  import asrtab_pkg::*;

  localparam int ENTRIES         = 256;
  localparam int BYTES_PER_ENTRY = 5;
  // Bytes that an entry keeps, limited to what the reading field can carry.
  localparam int KEPT_BYTES = (BYTES_PER_ENTRY > 5) ? 5 :
                              ((BYTES_PER_ENTRY < 1) ? 1 : BYTES_PER_ENTRY);
  localparam logic [39:0] KEPT_MASK = {40{1'b1}} << (40 - 8 * KEPT_BYTES);

  // Hex text of an all-zero and an all-ones reading.
  localparam logic [39:0] HEX_ZEROS = 40'h30_3030_3030;
  localparam logic [39:0] HEX_EFFS  = 40'h46_4646_4646;

  // The slowest item is a sweep, which visits every entry; some 575 items with
  // idle gaps between bursts fit well within this limit.
  localparam int CYCLE_LIMIT   = 800000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int PHASES        = 5;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] reading;
    logic [39:0] hex_hi;
    logic [39:0] hex_lo;
    logic        live;
    logic [8:0]  cleared;
    logic        stale;
  } result_t;

  typedef struct packed {
    action_t     act;
    logic [7:0]  idx;
    logic [39:0] rdg;
    logic [31:0] now;
  } cmd_t;

  typedef enum logic {ROW_ITEM, ROW_TIMEOUT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [15:0] tmo;
    logic        typed;
    result_t     want;
  } row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [7:0]  device_index;
  logic [39:0] reading;
  logic [31:0] now_ticks;
  logic        done;
  logic [1:0]  status;
  logic [39:0] reading_out;
  logic [39:0] hex_high;
  logic [39:0] hex_low;
  logic        entry_live;
  logic [8:0]  cleared_count;
  logic        stale_seen;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  aging_sensor_reading_table_top #(
    .ENTRIES         (ENTRIES),
    .BYTES_PER_ENTRY (BYTES_PER_ENTRY)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .device_index  (device_index),
    .reading       (reading),
    .now_ticks     (now_ticks),
    .done          (done),
    .status        (status),
    .reading_out   (reading_out),
    .hex_high      (hex_high),
    .hex_low       (hex_low),
    .entry_live    (entry_live),
    .cleared_count (cleared_count),
    .stale_seen    (stale_seen),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------
  // The model keeps its own copy of the readings, the arrival stamps, the
  // sticky stale flag and the timeout. It is stepped once for every item the
  // block accepts, so its state always matches what the block should hold.
  logic [39:0] model_reading [ENTRIES];
  logic [31:0] model_stamp [ENTRIES];
  logic        model_stale;
  logic [15:0] model_timeout;

  result_t pending_results [$];
  int      mismatch_count;
  int      cycle_count;

  // One uppercase hex character; letters follow the digits with a gap.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'd0, nib};
    end
    return 8'h41 + {4'd0, nib} - 8'd10;
  endfunction

  // Five characters for twenty bits, the top nibble first.
  function automatic logic [39:0] hex_text(input logic [19:0] bits);
    logic [39:0] txt;
    txt = '0;
    for (int k = 0; k < 5; k++) begin
      txt = {txt[31:0], hex_char(bits[19 - 4 * k -: 4])};
    end
    return txt;
  endfunction

  function automatic result_t make_result(input logic [1:0] st, input logic [39:0] rd,
                                          input logic [39:0] hh, input logic [39:0] hl,
                                          input logic lv, input logic [8:0] cnt,
                                          input logic stl);
    result_t r;
    r.status  = st;
    r.reading = rd;
    r.hex_hi  = hh;
    r.hex_lo  = hl;
    r.live    = lv;
    r.cleared = cnt;
    r.stale   = stl;
    return r;
  endfunction

  // Applies one item to the model and returns the result it should give.
  function automatic result_t predict_table_result(input cmd_t c);
    result_t     r;
    int          slot;
    logic [31:0] age_limit;
    logic [31:0] age;
    r = '0;
    case (c.act)
      ACT_STORE, ACT_READ: begin
        if (c.idx == 8'd0) begin
          r.status = STAT_ZERO;
        end else if (int'(c.idx) > ENTRIES) begin
          r.status = STAT_RANGE;
        end else begin
          slot = int'(c.idx) - 1;
          if (c.act == ACT_STORE) begin
            model_reading[slot] = c.rdg & KEPT_MASK;
            model_stamp[slot]   = c.now;
          end else begin
            r.reading = model_reading[slot];
            r.hex_hi  = hex_text(model_reading[slot][39:20]);
            r.hex_lo  = hex_text(model_reading[slot][19:0]);
          end
          r.status = STAT_DONE;
          r.live   = (model_stamp[slot] != 32'd0);
        end
      end
      ACT_SWEEP: begin
        age_limit = 32'(model_timeout) * 32'(TICKS_PER_MINUTE);
        for (int i = 0; i < ENTRIES; i++) begin
          age = c.now - model_stamp[i];
          if (model_stamp[i] != 32'd0 && age >= age_limit) begin
            model_stamp[i]   = '0;
            model_reading[i] = '0;
            model_stale      = 1'b1;
            if (r.cleared != 9'h1FF) begin
              r.cleared = r.cleared + 9'd1;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) begin
          model_stamp[i]   = '0;
          model_reading[i] = '0;
        end
      end
    endcase
    r.stale = model_stale;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  // A result is flagged by done for exactly one cycle, so it is taken at the
  // rising edge that ends the cycle with done high. Values read straight
  // after the edge are those from before it.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && done) begin
      got = make_result(status, reading_out, hex_high, hex_low, entry_live,
                        cleared_count, stale_seen);
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: result with no item outstanding: %p", $realtime, got);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.reading !== want.reading ||
            got.hex_hi !== want.hex_hi || got.hex_lo !== want.hex_lo ||
            got.live !== want.live || got.cleared !== want.cleared ||
            got.stale !== want.stale) begin
          if (mismatch_count < 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
          mismatch_count++;
        end
      end
    end
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding",
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  row_t stim_rows [$];

  task automatic add_row(input row_kind_t kind, input action_t act, input logic [7:0] idx,
                         input logic [39:0] rdg, input logic [31:0] now,
                         input logic [15:0] tmo, input logic typed, input result_t want);
    row_t row;
    row.kind    = kind;
    row.cmd.act = act;
    row.cmd.idx = idx;
    row.cmd.rdg = rdg;
    row.cmd.now = now;
    row.tmo     = tmo;
    row.typed   = typed;
    row.want    = want;
    stim_rows.push_back(row);
  endtask

  // Offers one item from a falling edge and holds it until the block takes
  // it. Returns at the next falling edge with start still high, so that a
  // following item in the same burst goes out without a gap.
  task automatic issue_item(input cmd_t c, input logic typed, input result_t want);
    result_t predicted;
    start        = 1'b1;
    action       = c.act;
    device_index = c.idx;
    reading      = c.rdg;
    now_ticks    = c.now;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predicted = predict_table_result(c);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // The timeout is only changed with the block idle: the sender holds off
  // until every outstanding result has come back.
  task automatic write_timeout(input logic [15:0] value);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) begin
      @(negedge clk);
    end
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en     = 1'b0;
    model_timeout = value;
  endtask

  initial begin
    cmd_t        c;
    result_t     none;
    logic [15:0] phase_tmo [PHASES];
    logic [31:0] tnow;
    int unsigned scale;
    int          sel;
    int          burst_left;
    logic        no_gaps;

    none           = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    rst            = 1'b1;
    start          = 1'b0;
    action         = ACT_STORE;
    device_index   = '0;
    reading        = '0;
    now_ticks      = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      model_reading[i] = '0;
      model_stamp[i]   = '0;
    end
    model_stale   = 1'b0;
    model_timeout = 16'd1;

    // Directed items. Results that are plain from the fields are typed in;
    // the rest come from the model.
    // An empty table reads back as zero with hex text of zeros.
    add_row(ROW_ITEM, ACT_READ, 8'd1, '1, '0, '0, 1'b1,
            make_result(STAT_DONE, '0, HEX_ZEROS, HEX_ZEROS, 1'b0, '0, 1'b0));
    // Index zero is ignored for both store and read.
    add_row(ROW_ITEM, ACT_STORE, 8'd0, '1, 32'd500, '0, 1'b1,
            make_result(STAT_ZERO, '0, '0, '0, 1'b0, '0, 1'b0));
    add_row(ROW_ITEM, ACT_READ, 8'd0, '0, '0, '0, 1'b1,
            make_result(STAT_ZERO, '0, '0, '0, 1'b0, '0, 1'b0));
    // All ones in the reading and stamp of the first entry.
    add_row(ROW_ITEM, ACT_STORE, 8'd1, '1, '1, '0, 1'b1,
            make_result(STAT_DONE, '0, '0, '0, 1'b1, '0, 1'b0));
    add_row(ROW_ITEM, ACT_READ, 8'd1, '0, '0, '0, 1'b1,
            make_result(STAT_DONE, '1, HEX_EFFS, HEX_EFFS, 1'b1, '0, 1'b0));
    // A store at tick zero writes the reading but leaves the entry not live.
    add_row(ROW_ITEM, ACT_STORE, 8'd255, '0, '0, '0, 1'b1,
            make_result(STAT_DONE, '0, '0, '0, 1'b0, '0, 1'b0));
    add_row(ROW_ITEM, ACT_READ, 8'd255, '0, '0, '0, 1'b1,
            make_result(STAT_DONE, '0, HEX_ZEROS, HEX_ZEROS, 1'b0, '0, 1'b0));
    add_row(ROW_ITEM, ACT_STORE, 8'd2, 40'h01_2345_6789, 32'd100, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_READ, 8'd2, '0, '0, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_STORE, 8'd3, 40'hAB_CDEF_0123, 32'd6100, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_STORE, 8'd128, 40'h80_0000_0001, 32'd1, '0, 1'b0, none);
    // Ages one short of, and then exactly at, the one minute timeout; the
    // stamp ahead of the sweep time wraps to a huge age.
    add_row(ROW_ITEM, ACT_SWEEP, 8'd0, '0, 32'd6099, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_SWEEP, 8'd0, '0, 32'd6100, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_READ, 8'd3, '0, '0, '0, 1'b0, none);
    // A zero timeout expires every live entry, whatever its age.
    add_row(ROW_TIMEOUT, ACT_STORE, '0, '0, '0, 16'd0, 1'b0, none);
    add_row(ROW_ITEM, ACT_STORE, 8'd4, 40'h5A_A55A_A55A, '1, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_STORE, 8'd5, 40'hA5_5AA5_5AA5, 32'd5, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_SWEEP, 8'd0, '0, 32'd5, '0, 1'b0, none);
    // The longest timeout, just short of and then at the limit.
    add_row(ROW_TIMEOUT, ACT_STORE, '0, '0, '0, 16'hFFFF, 1'b0, none);
    add_row(ROW_ITEM, ACT_STORE, 8'd6, 40'h12_3456_789A, 32'h8000_0000, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_SWEEP, 8'd0, '0, 32'h8000_0000 + 32'd393209999, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_SWEEP, 8'd0, '0, 32'h8000_0000 + 32'd393210000, '0, 1'b0, none);
    // Clear-all empties the table but keeps the stale flag.
    add_row(ROW_ITEM, ACT_STORE, 8'd7, 40'hFE_DCBA_9876, 32'd42, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_CLEAR, 8'd7, '0, '0, '0, 1'b0, none);
    add_row(ROW_ITEM, ACT_READ, 8'd7, '0, '0, '0, 1'b0, none);

    // Synchronous reset, released at a falling edge. The block
    // then clears its table with busy high, which the handshake waits out.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_timeout(16'd1);
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_TIMEOUT) begin
        write_timeout(stim_rows[i].tmo);
      end else begin
        issue_item(stim_rows[i].cmd, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random traffic in phases, each under its own timeout. Time mostly runs
    // forward in steps scaled to the timeout so that sweeps find entries on
    // both sides of the limit; a few items jump far ahead or use a stray
    // time. Most indexes fall in a small set of devices so that reads and
    // sweeps meet stored entries.
    phase_tmo[0] = 16'd1;
    phase_tmo[1] = 16'd0;
    phase_tmo[2] = 16'($urandom_range(2, 200));
    phase_tmo[3] = 16'hFFFF;
    phase_tmo[4] = 16'd3;
    burst_left   = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_timeout(phase_tmo[ph]);
      scale   = (phase_tmo[ph] == 16'd0) ? 6000 : int'(phase_tmo[ph]) * 6000;
      tnow    = $urandom;
      // One phase runs back to back with no idle cycles at all.
      no_gaps = (ph == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          c.act = ACT_STORE;
        end else if (sel < 80) begin
          c.act = ACT_READ;
        end else if (sel < 94) begin
          c.act = ACT_SWEEP;
        end else begin
          c.act = ACT_CLEAR;
        end

        if ($urandom_range(0, 99) < 4) begin
          tnow = tnow + $urandom_range(0, 2 * scale);
        end else begin
          tnow = tnow + $urandom_range(0, scale / 6);
        end
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          c.now = $urandom;
        end else if (sel < 8) begin
          c.now = '0;
        end else begin
          c.now = tnow;
        end

        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          c.idx = 8'($urandom_range(1, 12));
        end else if (sel < 80) begin
          c.idx = 8'd0;
        end else if (sel < 88) begin
          c.idx = 8'($urandom_range(250, 255));
        end else begin
          c.idx = 8'($urandom_range(0, 255));
        end

        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          c.rdg = '1;
        end else if (sel < 10) begin
          c.rdg = '0;
        end else begin
          c.rdg = {8'($urandom), 32'($urandom)};
        end

        issue_item(c, 1'b0, none);

        // Bursts of random length with idle stretches between them.
        if (!no_gaps) begin
          if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
    end

    // Let the last results come back, then a drain period for anything extra.
    start = 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failing results", mismatch_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
